@@ rtl/csmv_pkg.sv @@
// Shared types, widths and codes for the CSR sparse matrix-vector multiplier.
package csmv_pkg;

  localparam int VECTOR_DEPTH_DEF  = 4096;
  localparam int FRACTION_BITS_DEF = 16;

  localparam int POS_W  = 12;
  localparam int DATA_W = 32;
  localparam int ACC_W  = 64;
  localparam int ROW_W  = 16;
  localparam int VLEN_W = 13;

  localparam logic [VLEN_W-1:0] VLEN_RESET = 13'd4096;

  typedef logic [1:0] kind_t;
  localparam kind_t KIND_LOAD    = 2'd0;
  localparam kind_t KIND_NONZERO = 2'd1;
  localparam kind_t KIND_EMPTY   = 2'd2;

  // Operation handed from the vector read stage to the multiply-accumulate stage.
  typedef struct packed {
    logic                     add_en;
    logic                     bad;
    logic                     finish;
    logic                     last;
    logic signed [DATA_W-1:0] value;
  } mac_op_t;

  // Finished row, still in accumulator format.
  typedef struct packed {
    logic signed [ACC_W-1:0] acc;
    logic                    ovf;
    logic                    bad;
    logic [ROW_W-1:0]        row_number;
    logic                    last;
  } row_res_t;

endpackage

@@ rtl/csmv_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module csmv_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

@@ rtl/csmv_mac.sv @@
// Multiply stage, saturating 64-bit accumulator and finished-row register.
module csmv_mac import csmv_pkg::*; (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     op_valid,
  input  mac_op_t                  op,
  input  logic signed [DATA_W-1:0] x_data,
  output logic                     op_ready,
  output logic                     res_valid,
  output row_res_t                 res,
  input  logic                     res_ready
);

  localparam logic signed [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
  localparam logic signed [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};

  logic                    s2_v_r, s2_v_nxt;
  logic signed [ACC_W-1:0] s2_prod_r;
  logic                    s2_bad_r, s2_finish_r, s2_last_r;

  logic signed [ACC_W-1:0] acc_r, acc_nxt;
  logic                    ovf_r, ovf_nxt;
  logic                    bad_r, bad_nxt;
  logic [ROW_W-1:0]        row_r, row_nxt;

  logic     res_v_r, res_v_nxt;
  row_res_t res_r;

  logic signed [ACC_W-1:0] prod;
  logic signed [ACC_W:0]   sum_ext;
  logic signed [ACC_W-1:0] sum_sat;
  logic                    sum_ovf;
  logic                    s2_fire;
  logic                    row_done;

  assign prod = op.value * x_data;

  // Extra sign bit catches 64-bit overflow of the add.
  assign sum_ext = {acc_r[ACC_W-1], acc_r} + {s2_prod_r[ACC_W-1], s2_prod_r};
  assign sum_ovf = sum_ext[ACC_W] != sum_ext[ACC_W-1];
  assign sum_sat = !sum_ovf ? sum_ext[ACC_W-1:0] : (sum_ext[ACC_W] ? ACC_MIN : ACC_MAX);

  assign s2_fire  = s2_v_r && (!s2_finish_r || !res_v_r || res_ready);
  assign row_done = s2_fire && s2_finish_r;
  assign op_ready = !s2_v_r || s2_fire;

  always_comb begin
    s2_v_nxt = s2_v_r;
    if (op_ready) begin
      s2_v_nxt = op_valid;
    end
  end

  always_comb begin
    acc_nxt = acc_r;
    ovf_nxt = ovf_r;
    bad_nxt = bad_r;
    row_nxt = row_r;
    if (s2_fire) begin
      if (s2_finish_r) begin
        acc_nxt = '0;
        ovf_nxt = 1'b0;
        bad_nxt = 1'b0;
        row_nxt = s2_last_r ? '0 : row_r + 1'b1;
      end else begin
        acc_nxt = sum_sat;
        ovf_nxt = ovf_r | sum_ovf;
        bad_nxt = bad_r | s2_bad_r;
      end
    end
  end

  always_comb begin
    res_v_nxt = res_v_r;
    if (row_done) begin
      res_v_nxt = 1'b1;
    end else if (res_ready) begin
      res_v_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_v_r  <= 1'b0;
      res_v_r <= 1'b0;
      acc_r   <= '0;
      ovf_r   <= 1'b0;
      bad_r   <= 1'b0;
      row_r   <= '0;
    end else begin
      s2_v_r  <= s2_v_nxt;
      res_v_r <= res_v_nxt;
      acc_r   <= acc_nxt;
      ovf_r   <= ovf_nxt;
      bad_r   <= bad_nxt;
      row_r   <= row_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (op_ready && op_valid) begin
      s2_prod_r   <= op.add_en ? prod : '0;
      s2_bad_r    <= op.bad;
      s2_finish_r <= op.finish;
      s2_last_r   <= op.last;
    end
    if (row_done) begin
      res_r.acc        <= sum_sat;
      res_r.ovf        <= ovf_r | sum_ovf;
      res_r.bad        <= bad_r | s2_bad_r;
      res_r.row_number <= row_r;
      res_r.last       <= s2_last_r;
    end
  end

  assign res_valid = res_v_r;
  assign res       = res_r;

endmodule

@@ rtl/csmv_fmt.sv @@
// Q32.32 to Q16.16 conversion with floor rounding and saturation, plus output register.
module csmv_fmt import csmv_pkg::*; #(
  parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     res_valid,
  input  row_res_t                 res,
  output logic                     res_ready,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic [ROW_W-1:0]         out_row_number,
  output logic signed [DATA_W-1:0] out_row_sum,
  output logic                     out_overflowed,
  output logic                     out_bad_column,
  output logic                     out_last
);

  localparam logic signed [ACC_W-1:0] SUM_MAX =
    {{(ACC_W-DATA_W+1){1'b0}}, {(DATA_W-1){1'b1}}};
  localparam logic signed [ACC_W-1:0] SUM_MIN =
    {{(ACC_W-DATA_W+1){1'b1}}, {(DATA_W-1){1'b0}}};

  logic                     out_v_r, out_v_nxt;
  logic [ROW_W-1:0]         row_number_r;
  logic signed [DATA_W-1:0] row_sum_r;
  logic                     ovf_r, bad_r, last_r;

  logic signed [ACC_W-1:0]  shifted;
  logic signed [DATA_W-1:0] sum_sat;
  logic                     conv_ovf;
  logic                     load;

  // Arithmetic shift gives floor rounding.
  assign shifted = res.acc >>> FRACTION_BITS;

  always_comb begin
    conv_ovf = 1'b0;
    sum_sat  = shifted[DATA_W-1:0];
    if (shifted > SUM_MAX) begin
      conv_ovf = 1'b1;
      sum_sat  = SUM_MAX[DATA_W-1:0];
    end else if (shifted < SUM_MIN) begin
      conv_ovf = 1'b1;
      sum_sat  = SUM_MIN[DATA_W-1:0];
    end
  end

  assign res_ready = !out_v_r || !out_stall;
  assign load      = res_valid && res_ready;

  always_comb begin
    out_v_nxt = out_v_r;
    if (load) begin
      out_v_nxt = 1'b1;
    end else if (!out_stall) begin
      out_v_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else begin
      out_v_r <= out_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      row_number_r <= res.row_number;
      row_sum_r    <= sum_sat;
      ovf_r        <= res.ovf | conv_ovf;
      bad_r        <= res.bad;
      last_r       <= res.last;
    end
  end

  assign out_valid      = out_v_r;
  assign out_row_number = row_number_r;
  assign out_row_sum    = row_sum_r;
  assign out_overflowed = ovf_r;
  assign out_bad_column = bad_r;
  assign out_last       = last_r;

endmodule

@@ rtl/csr_sparse_matrix_vector_multiply.sv @@
// CSR sparse matrix times dense vector: one item per cycle while in_stall is low, Q16.16 row sums.
// Throughput: one item per clock unless in_stall is raised; vector store has one write and one read port.
// A finishing item passes the vector read, multiply, finished-row and output registers; stalls can hold it.
// Pipeline: vector read, multiply, saturating accumulate, conversion/output register.
// Reset clears control, accumulator, row counter, flags and sets vector_length to 4096.
// The vector store is not cleared; entries must be loaded before they are used.
module csr_sparse_matrix_vector_multiply import csmv_pkg::*; #(
  parameter int VECTOR_DEPTH  = VECTOR_DEPTH_DEF,
  parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic [1:0]               in_kind,
  input  logic [POS_W-1:0]         in_position,
  input  logic signed [DATA_W-1:0] in_value,
  input  logic                     in_row_end,
  input  logic                     in_final_row,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic [ROW_W-1:0]         out_row_number,
  output logic signed [DATA_W-1:0] out_row_sum,
  output logic                     out_overflowed,
  output logic                     out_bad_column,
  output logic                     out_last,
  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  logic [VLEN_W-1:0]        cfg_vector_length
);

  localparam int AW = $clog2(VECTOR_DEPTH);

  logic [VLEN_W-1:0] vlen_r, vlen_nxt;

  logic    s1_v_r, s1_v_nxt;
  mac_op_t s1_op_r;
  logic    s1_ready;
  logic    mac_ready;

  logic                     in_accept;
  logic                     is_load, is_nz, is_empty;
  logic                     depth_ok, in_range;
  logic [POS_W+AW-1:0]      pos_ext;
  logic [AW-1:0]            addr;
  logic                     wr_en, rd_en;
  logic [DATA_W-1:0]        rd_data;

  logic     res_valid, res_ready;
  row_res_t res;

  assign cfg_ready = 1'b1;

  always_comb begin
    vlen_nxt = vlen_r;
    if (cfg_valid && cfg_ready) begin
      vlen_nxt = cfg_vector_length;
    end
  end

  assign is_load  = in_kind == KIND_LOAD;
  assign is_nz    = in_kind == KIND_NONZERO;
  assign is_empty = in_kind == KIND_EMPTY;

  assign pos_ext  = {{AW{1'b0}}, in_position};
  assign addr     = pos_ext[AW-1:0];
  assign depth_ok = 32'(in_position) < 32'(VECTOR_DEPTH);
  assign in_range = depth_ok && ({1'b0, in_position} < vlen_r);

  assign s1_ready  = !s1_v_r || mac_ready;
  assign in_stall  = !s1_ready;
  assign in_accept = in_valid && s1_ready;

  assign wr_en = in_accept && is_load && depth_ok;
  assign rd_en = in_accept && is_nz && in_range;

  // Only nonzero and empty-row items travel down the pipeline.
  always_comb begin
    s1_v_nxt = s1_v_r;
    if (s1_ready) begin
      s1_v_nxt = in_accept && (is_nz || is_empty);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vlen_r <= VLEN_RESET;
      s1_v_r <= 1'b0;
    end else begin
      vlen_r <= vlen_nxt;
      s1_v_r <= s1_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_op_r.add_en <= is_nz && in_range;
      s1_op_r.bad    <= is_nz && !in_range;
      s1_op_r.finish <= is_empty || in_row_end;
      s1_op_r.last   <= in_final_row;
      s1_op_r.value  <= in_value;
    end
  end

  csmv_ram #(
    .WIDTH (DATA_W),
    .DEPTH (VECTOR_DEPTH)
  ) u_vec_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (addr),
    .wr_data (in_value),
    .rd_en   (rd_en),
    .rd_addr (addr),
    .rd_data (rd_data)
  );

  csmv_mac u_mac (
    .clk       (clk),
    .rst_n     (rst_n),
    .op_valid  (s1_v_r),
    .op        (s1_op_r),
    .x_data    ($signed(rd_data)),
    .op_ready  (mac_ready),
    .res_valid (res_valid),
    .res       (res),
    .res_ready (res_ready)
  );

  csmv_fmt #(
    .FRACTION_BITS (FRACTION_BITS)
  ) u_fmt (
    .clk            (clk),
    .rst_n          (rst_n),
    .res_valid      (res_valid),
    .res            (res),
    .res_ready      (res_ready),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_row_number (out_row_number),
    .out_row_sum    (out_row_sum),
    .out_overflowed (out_overflowed),
    .out_bad_column (out_bad_column),
    .out_last       (out_last)
  );

endmodule

@@ test/csr_sparse_matrix_vector_multiply_tb.sv @@
// Self-checking testbench for the CSR sparse matrix-vector multiplier.
module csr_sparse_matrix_vector_multiply_tb;
  import csmv_pkg::*;

  localparam kind_t KIND_UNUSED = 2'd3;
  localparam int DRAIN_CYCLES = 10;
  localparam int MAX_REPORTS = 40;

  typedef struct packed {
    kind_t                    kind;
    logic [POS_W-1:0]         position;
    logic signed [DATA_W-1:0] value;
    logic                     row_end;
    logic                     final_row;
  } item_t;

  typedef struct packed {
    logic [ROW_W-1:0]         row_number;
    logic signed [DATA_W-1:0] row_sum;
    logic                     overflowed;
    logic                     bad_column;
    logic                     last;
  } row_out_t;

  // One row of the directed table; the expected result is used only when 'typed' is set.
  typedef struct packed {
    item_t    it;
    logic     typed;
    row_out_t want;
  } dir_step_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [1:0] in_kind = KIND_LOAD;
  logic [POS_W-1:0] in_position = '0;
  logic signed [DATA_W-1:0] in_value = '0;
  logic in_row_end = 1'b0;
  logic in_final_row = 1'b0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [ROW_W-1:0] out_row_number;
  logic signed [DATA_W-1:0] out_row_sum;
  logic out_overflowed;
  logic out_bad_column;
  logic out_last;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [VLEN_W-1:0] cfg_vector_length = VLEN_RESET;

  csr_sparse_matrix_vector_multiply dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_kind           (in_kind),
    .in_position       (in_position),
    .in_value          (in_value),
    .in_row_end        (in_row_end),
    .in_final_row      (in_final_row),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_row_number    (out_row_number),
    .out_row_sum       (out_row_sum),
    .out_overflowed    (out_overflowed),
    .out_bad_column    (out_bad_column),
    .out_last          (out_last),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_vector_length (cfg_vector_length)
  );

  always #5 clk = ~clk;

  // Shadow of the block's state
  logic signed [DATA_W-1:0] vec_img [VECTOR_DEPTH_DEF];
  bit                       vec_written [VECTOR_DEPTH_DEF];
  int                       written_idx [$];
  logic signed [ACC_W-1:0]  acc_img = '0;
  logic [ROW_W-1:0]         row_idx = '0;
  bit                       ovf_flag = 1'b0;
  bit                       bad_flag = 1'b0;
  logic [VLEN_W-1:0]        vlen_img = VLEN_RESET;

  row_out_t row_q [$];
  int fail_cnt = 0;
  int sent_items = 0;
  int send_idle = 0;
  int recv_stall = 0;

  always @(posedge clk) out_stall <= ($urandom_range(99) < recv_stall);

  task automatic close_row(input logic final_row);
    logic signed [ACC_W-1:0] shifted;
    row_out_t r;
    shifted = acc_img >>> FRACTION_BITS_DEF;  // arithmetic shift = floor
    r.overflowed = ovf_flag;
    if (shifted > 64'sd2147483647) begin
      r.row_sum = 32'h7fff_ffff;
      r.overflowed = 1'b1;
    end else if (shifted < -64'sd2147483648) begin
      r.row_sum = 32'h8000_0000;
      r.overflowed = 1'b1;
    end else begin
      r.row_sum = shifted[DATA_W-1:0];
    end
    r.row_number = row_idx;
    r.bad_column = bad_flag;
    r.last = final_row;
    row_q.push_back(r);
    acc_img = '0;
    ovf_flag = 1'b0;
    bad_flag = 1'b0;
    row_idx = final_row ? '0 : row_idx + 1'b1;
  endtask

  // Advance the shadow state by one transferred item, queueing any row result.
  task automatic predict_row(input item_t it);
    longint a;
    longint b;
    longint p;
    logic [ACC_W:0] wide;
    case (it.kind)
      KIND_LOAD: begin
        vec_img[it.position] = it.value;
        if (!vec_written[it.position]) begin
          vec_written[it.position] = 1'b1;
          written_idx.push_back(int'(it.position));
        end
      end
      KIND_NONZERO: begin
        if ({1'b0, it.position} < vlen_img) begin
          a = $signed(it.value);
          b = $signed(vec_img[it.position]);
          p = a * b;
          wide = {acc_img[ACC_W-1], acc_img} + {p[63], p};
          if (wide[ACC_W] != wide[ACC_W-1]) begin
            acc_img = wide[ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
            ovf_flag = 1'b1;
          end else begin
            acc_img = wide[ACC_W-1:0];
          end
        end else begin
          bad_flag = 1'b1;
        end
        if (it.row_end) close_row(it.final_row);
      end
      KIND_EMPTY: close_row(it.final_row);
      default: ;
    endcase
  endtask

  task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
    if (got !== want) begin
      fail_cnt++;
      if (fail_cnt <= MAX_REPORTS)
        $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
    end
  endtask

  always @(posedge clk) begin : result_check
    row_out_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (row_q.size() == 0) begin
        fail_cnt++;
        if (fail_cnt <= MAX_REPORTS)
          $display("%0t: unexpected row result, expected none, actual row %0d sum %0h",
                   $time, out_row_number, out_row_sum);
      end else begin
        want = row_q.pop_front();
        check_field("row_number", 32'(want.row_number), 32'(out_row_number));
        check_field("row_sum", want.row_sum, out_row_sum);
        check_field("overflowed", 32'(want.overflowed), 32'(out_overflowed));
        check_field("bad_column", 32'(want.bad_column), 32'(out_bad_column));
        check_field("last", 32'(want.last), 32'(out_last));
      end
    end
  end

  // Drive one item and hold it until it transfers.
  task automatic send_item(input item_t it);
    while ($urandom_range(99) < send_idle) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_kind <= it.kind;
    in_position <= it.position;
    in_value <= it.value;
    in_row_end <= it.row_end;
    in_final_row <= it.final_row;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (it.kind != KIND_UNUSED) sent_items++;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (row_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_vlen(input logic [VLEN_W-1:0] v);
    cfg_valid <= 1'b1;
    cfg_vector_length <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    vlen_img = v;
  endtask

  function automatic logic [31:0] pick_value();
    case ($urandom_range(9))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return '0;
      3: return '1;
      4, 5, 6: return $urandom;
      default: return $urandom_range(32'h0010_0000) - 32'h0008_0000;
    endcase
  endfunction

  function automatic int low_span();
    return (vlen_img < 32) ? int'(vlen_img) : 32;
  endfunction

  // In-range columns only hit loaded entries; out-of-range ones are never read.
  function automatic logic [POS_W-1:0] pick_column();
    int idx;
    if (vlen_img < VECTOR_DEPTH_DEF && $urandom_range(99) < 15)
      return POS_W'($urandom_range(VECTOR_DEPTH_DEF - 1, vlen_img));
    repeat (4) begin
      idx = written_idx[$urandom_range(written_idx.size() - 1)];
      if (idx < vlen_img) return POS_W'(idx);
    end
    return POS_W'($urandom_range(low_span() - 1));
  endfunction

  task automatic send_load(input logic [POS_W-1:0] pos);
    item_t it;
    it.kind = KIND_LOAD;
    it.position = pos;
    it.value = pick_value();
    it.row_end = 1'($urandom_range(1));
    it.final_row = 1'($urandom_range(1));
    send_item(it);
    predict_row(it);
  endtask

  task automatic send_row();
    item_t it;
    int len;
    bit heavy;
    bit broken;
    len = $urandom_range(6, 1);
    heavy = ($urandom_range(7) == 0);
    broken = ($urandom_range(19) == 0);
    for (int i = 0; i < len; i++) begin
      if ($urandom_range(19) == 0) send_load(POS_W'($urandom));
      it.kind = KIND_NONZERO;
      it.position = pick_column();
      it.value = heavy ? ($urandom_range(1) ? 32'h7fff_ffff : 32'h8000_0000) : pick_value();
      it.row_end = (i == len - 1) && !broken;
      it.final_row = (i == len - 1) ? ($urandom_range(7) == 0) : 1'($urandom_range(1));
      send_item(it);
      predict_row(it);
    end
  endtask

  task automatic run_phase(input bit do_cfg, input logic [VLEN_W-1:0] vlen,
                           input int send_pct, input int stall_pct, input int n);
    item_t it;
    int target;
    int pick;
    drain();
    if (do_cfg) write_vlen(vlen);
    send_idle = send_pct;
    recv_stall = stall_pct;
    for (int i = 0; i < low_span(); i++) send_load(POS_W'(i));
    target = sent_items + n;
    while (sent_items < target) begin
      pick = $urandom_range(99);
      if (pick < 10) begin
        repeat ($urandom_range(8, 1)) send_load(POS_W'($urandom));
      end else if (pick < 80) begin
        send_row();
      end else begin
        it.kind = (pick < 95) ? KIND_EMPTY : KIND_UNUSED;
        it.position = POS_W'($urandom);
        it.value = $urandom;
        it.row_end = 1'($urandom_range(1));
        it.final_row = ($urandom_range(5) == 0);
        send_item(it);
        predict_row(it);
      end
    end
  endtask

  dir_step_t dir_tab [21];

  initial begin
    dir_tab = '{
      '{'{KIND_EMPTY,   12'd0,    32'h0000_0000, 1'b0, 1'b0}, 1'b1,
        '{16'd0, 32'h0000_0000, 1'b0, 1'b0, 1'b0}},
      '{'{KIND_LOAD,    12'd0,    32'h0001_0000, 1'b0, 1'b0}, 1'b0, '0},
      '{'{KIND_LOAD,    12'd4095, 32'h7fff_ffff, 1'b0, 1'b0}, 1'b0, '0},
      '{'{KIND_LOAD,    12'd1,    32'h8000_0000, 1'b0, 1'b0}, 1'b0, '0},
      // a load never closes a row, whatever its flags
      '{'{KIND_LOAD,    12'd2,    32'h0002_0000, 1'b1, 1'b1}, 1'b0, '0},
      '{'{KIND_LOAD,    12'd5,    32'h0000_0001, 1'b0, 1'b0}, 1'b0, '0},
      '{'{KIND_NONZERO, 12'd2,    32'h0003_0000, 1'b1, 1'b0}, 1'b1,
        '{16'd1, 32'h0006_0000, 1'b0, 1'b0, 1'b0}},
      // third max product saturates the accumulator high
      '{'{KIND_NONZERO, 12'd4095, 32'h7fff_ffff, 1'b0, 1'b0}, 1'b0, '0},
      '{'{KIND_NONZERO, 12'd4095, 32'h7fff_ffff, 1'b0, 1'b0}, 1'b0, '0},
      '{'{KIND_NONZERO, 12'd4095, 32'h7fff_ffff, 1'b1, 1'b0}, 1'b1,
        '{16'd2, 32'h7fff_ffff, 1'b1, 1'b0, 1'b0}},
      // and low
      '{'{KIND_NONZERO, 12'd1,    32'h7fff_ffff, 1'b0, 1'b0}, 1'b0, '0},
      '{'{KIND_NONZERO, 12'd1,    32'h7fff_ffff, 1'b0, 1'b0}, 1'b0, '0},
      '{'{KIND_NONZERO, 12'd1,    32'h7fff_ffff, 1'b1, 1'b0}, 1'b1,
        '{16'd3, 32'h8000_0000, 1'b1, 1'b0, 1'b0}},
      '{'{KIND_UNUSED,  12'd7,    32'h1234_5678, 1'b1, 1'b1}, 1'b0, '0},
      // floor rounding of a tiny negative sum
      '{'{KIND_NONZERO, 12'd5,    32'hffff_ffff, 1'b1, 1'b1}, 1'b1,
        '{16'd4, 32'hffff_ffff, 1'b0, 1'b0, 1'b1}},
      '{'{KIND_EMPTY,   12'd0,    32'h0000_0000, 1'b1, 1'b1}, 1'b1,
        '{16'd0, 32'h0000_0000, 1'b0, 1'b0, 1'b1}},
      '{'{KIND_NONZERO, 12'd2,    32'h0001_0000, 1'b0, 1'b0}, 1'b0, '0},
      // empty-row item closes the open row
      '{'{KIND_EMPTY,   12'd0,    32'h0000_0000, 1'b1, 1'b0}, 1'b1,
        '{16'd0, 32'h0002_0000, 1'b0, 1'b0, 1'b0}},
      '{'{KIND_NONZERO, 12'd0,    32'h8000_0000, 1'b0, 1'b0}, 1'b0, '0},
      '{'{KIND_NONZERO, 12'd1,    32'h8000_0000, 1'b1, 1'b0}, 1'b0, '0},
      '{'{KIND_NONZERO, 12'd0,    32'h0000_0001, 1'b1, 1'b0}, 1'b0, '0}
    };

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_tab[i]) begin
      send_item(dir_tab[i].it);
      predict_row(dir_tab[i].it);
      if (dir_tab[i].typed) begin
        void'(row_q.pop_back());
        row_q.push_back(dir_tab[i].want);
      end
    end

    run_phase(1'b0, VLEN_RESET, 0, 0, 160);
    run_phase(1'b1, 13'd1, 77, 0, 160);
    run_phase(1'b1, 13'd4096, 0, 77, 160);
    run_phase(1'b1, 13'd37, 28, 28, 160);
    run_phase(1'b1, VLEN_W'($urandom_range(4095, 2)), 0, 0, 160);
    run_phase(1'b1, 13'd4095, 28, 28, 160);

    drain();
    if (fail_cnt == 0)
      $display("[csr_sparse_matrix_vector_multiply] OK");
    else
      $display("[csr_sparse_matrix_vector_multiply] ERROR");
    $finish;
  end

  initial begin
    #5000000;
    $display("[csr_sparse_matrix_vector_multiply] ERROR");
    $finish;
  end

endmodule

@@ sim.f @@
rtl/csmv_pkg.sv
rtl/csmv_ram.sv
rtl/csmv_mac.sv
rtl/csmv_fmt.sv
rtl/csr_sparse_matrix_vector_multiply.sv
test/csr_sparse_matrix_vector_multiply_tb.sv
